/* hdl/pga_pkg.sv */
// Shared widths, register indexes and reset values of the pairwise gravity block.
// No dependencies; taken in by the top level, the checker and the testbench.
`default_nettype none

package pga_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COORD_FRAC_DEF  = 8;

    localparam int MASS_W   = 32;
    localparam int GRAV_W   = 32;
    localparam int SCALE_W  = 16;
    localparam int DSQ_W    = 32;
    localparam int ACC_W    = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAV  = 2'd0,
        CFG_SCALE = 2'd1,
        CFG_MIN   = 2'd2,
        CFG_MAX   = 2'd3
    } cfg_idx_t;

    localparam logic [GRAV_W-1:0]  GRAV_RST  = 32'd10000;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd100;
    localparam logic [DSQ_W-1:0]   MIN_RST   = 32'd10000;
    localparam logic [DSQ_W-1:0]   MAX_RST   = 32'd100000000;

    // signed Q32.16 range limits of a result component
    localparam logic signed [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_NEG_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

`default_nettype wire

/* hdl/pga_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Generic; no package dependencies.
`default_nettype none

module pga_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);

    logic          vld_reg  [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] wrd_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          vld_k;
        logic [DW-1:0] rem_k;
        logic [DW-1:0] den_k;
        logic [QW-1:0] wrd_k;
        logic [SW-1:0] side_k;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] wrd_next;

        if (k == 0) begin : g_first
            assign vld_k  = in_valid;
            assign rem_k  = rem_in;
            assign den_k  = den_in;
            assign wrd_k  = num_in;
            assign side_k = side_in;
        end else begin : g_rest
            assign vld_k  = vld_reg[k-1];
            assign rem_k  = rem_reg[k-1];
            assign den_k  = den_reg[k-1];
            assign wrd_k  = wrd_reg[k-1];
            assign side_k = side_reg[k-1];
        end

        // numerator bits leave at the top of the word, quotient bits enter at the bottom
        assign trial    = {rem_k, wrd_k[QW-1]};
        assign ge       = trial >= {1'b0, den_k};
        assign rem_next = ge ? DW'(trial - {1'b0, den_k}) : trial[DW-1:0];
        assign wrd_next = {wrd_k[QW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_k;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                wrd_reg[k]  <= wrd_next;
                den_reg[k]  <= den_k;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quot      = wrd_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire

/* hdl/pga_sqrt_pipe.sv */
// Pipelined integer square root, one root bit per stage, with a sideband.
// Generic; no package dependencies.
`default_nettype none

module pga_sqrt_pipe #(
    parameter int RW = 32,
    parameter int SW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] rad_in,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);

    logic            vld_reg  [RW];
    logic [RW:0]     rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [SW-1:0]   side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            vld_k;
        logic [RW:0]     rem_k;
        logic [RW-1:0]   root_k;
        logic [2*RW-1:0] rad_k;
        logic [SW-1:0]   side_k;
        logic [RW+2:0]   acc;
        logic [RW+2:0]   trial;
        logic            ge;
        logic [RW:0]     rem_next;
        logic [RW-1:0]   root_next;
        logic [2*RW-1:0] rad_next;

        if (k == 0) begin : g_first
            assign vld_k  = in_valid;
            assign rem_k  = '0;
            assign root_k = '0;
            assign rad_k  = rad_in;
            assign side_k = side_in;
        end else begin : g_rest
            assign vld_k  = vld_reg[k-1];
            assign rem_k  = rem_reg[k-1];
            assign root_k = root_reg[k-1];
            assign rad_k  = rad_reg[k-1];
            assign side_k = side_reg[k-1];
        end

        // bring down two radicand bits, try (4*root + 1)
        assign acc       = {rem_k, rad_k[2*RW-1 -: 2]};
        assign trial     = {1'b0, root_k, 2'b01};
        assign ge        = acc >= trial;
        assign rem_next  = ge ? (RW+1)'(acc - trial) : acc[RW:0];
        assign root_next = {root_k[RW-2:0], ge};
        assign rad_next  = {rad_k[2*RW-3:0], 2'b00};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_k;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

`default_nettype wire

/* hdl/pairwise_gravity_accel_top.sv */
// Top level of the pairwise gravity acceleration block: one body pair in, one Q32.16 vector out.
// Depends on pga_pkg, pga_sqrt_pipe and pga_div_pipe.
//
// Usage:
//   Input channel (s_*): one transaction per body pair: source and target positions
//   (signed Q.COORD_FRAC), both masses (unsigned Q16.16) and the target's still flag.
//   Output channel (m_*): one transaction per input transaction, in order: the
//   acceleration increment per axis (signed Q32.16) and a flag set when any
//   component was clipped to range. Still targets and coincident bodies give zero.
//   Configuration: cfg_we writes cfg_wdata into the register chosen by cfg_index
//   (gravity constant, force scale, lower and upper distance-squared bounds).
//   Write only while no transaction is in flight.
// Pipeline: a bit-serial chain of 32 root stages, 32 unit-vector divide stages,
//   96 strength divide stages and 128 mass divide stages, plus 13 stages of
//   multiply, shift and clamp.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset: aresetn low clears every stage valid and the output valid; registers
//   return to their reset values. Payload registers are not reset.
// Stall: while m_valid is high and m_ready low the whole pipeline holds and
//   s_ready drops; nothing is lost or repeated.
`default_nettype none

module pairwise_gravity_accel_top #(
    parameter int COORD_WIDTH = pga_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC  = pga_pkg::COORD_FRAC_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [pga_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pga_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_WIDTH-1:0]       s_src_x,
    input  logic signed [COORD_WIDTH-1:0]       s_src_y,
    input  logic signed [COORD_WIDTH-1:0]       s_src_z,
    input  logic signed [COORD_WIDTH-1:0]       s_tgt_x,
    input  logic signed [COORD_WIDTH-1:0]       s_tgt_y,
    input  logic signed [COORD_WIDTH-1:0]       s_tgt_z,
    input  logic [pga_pkg::MASS_W-1:0]          s_src_mass,
    input  logic [pga_pkg::MASS_W-1:0]          s_tgt_mass,
    input  logic                                s_tgt_still,
    // output channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pga_pkg::ACC_W-1:0]    m_acc_x,
    output logic signed [pga_pkg::ACC_W-1:0]    m_acc_y,
    output logic signed [pga_pkg::ACC_W-1:0]    m_acc_z,
    output logic                                m_saturated
);

    import pga_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int NORM_W = 31;                  // normalized magnitude, top bit at 2^30
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SUM_W  = 64;                  // sum of three squares
    localparam int ROOT_W = SUM_W / 2;
    localparam int UNIT_W = 32;                  // Q1.31 unit component
    localparam int PM_W   = 2 * MASS_W;
    localparam int PG_W   = PM_W + GRAV_W;
    localparam int F_W    = PG_W + SCALE_W;
    localparam int N2_W   = F_W + 16;            // force shifted for the mass divide
    localparam int CLIP_W = 95;                  // force clipped below 2^95
    localparam int PRD_W  = CLIP_W + UNIT_W;
    localparam int SHR    = 47;
    localparam int R_W    = PRD_W - SHR;
    localparam int LW     = $clog2(W + 1);
    localparam int EW     = $clog2(2 * W + 2 * NORM_W + 2 * COORD_FRAC + 2) + 1;
    localparam int SH_W   = $clog2(DSQ_W);
    localparam int RSH_W  = $clog2(SUM_W);

    localparam logic [R_W-1:0] R_POS_LIM = R_W'({(ACC_W-1){1'b1}});
    localparam logic [R_W-1:0] R_NEG_LIM = R_W'(1) << (ACC_W - 1);

    typedef struct packed {
        logic                        kill;
        logic [2:0]                  neg;
        logic [2:0][NORM_W-1:0]      m;
        logic [PG_W-1:0]             pg;
        logic [DSQ_W-1:0]            dsq;
        logic [MASS_W-1:0]           tmass;
    } sq_side_t;

    typedef struct packed {
        logic                        kill;
        logic                        neg;
        logic [PG_W-1:0]             pg;
        logic [DSQ_W-1:0]            dsq;
        logic [MASS_W-1:0]           tmass;
    } ud_side_t;

    typedef struct packed {
        logic                        kill;
        logic [2:0]                  neg;
        logic [2:0][UNIT_W-1:0]      u;
        logic [MASS_W-1:0]           tmass;
    } d1_side_t;

    typedef struct packed {
        logic                        kill;
        logic [2:0]                  neg;
        logic [2:0][UNIT_W-1:0]      u;
    } d2_side_t;

    // ---------------------------------------------------------------- config
    logic [GRAV_W-1:0]  grav_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [DSQ_W-1:0]   min_reg;
    logic [DSQ_W-1:0]   max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg  <= GRAV_RST;
            scale_reg <= SCALE_RST;
            min_reg   <= MIN_RST;
            max_reg   <= MAX_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_GRAV:  grav_reg  <= cfg_wdata[GRAV_W-1:0];
                CFG_SCALE: scale_reg <= cfg_wdata[SCALE_W-1:0];
                CFG_MIN:   min_reg   <= cfg_wdata[DSQ_W-1:0];
                CFG_MAX:   max_reg   <= cfg_wdata[DSQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    // Whole pipeline advances together; the output register parts the two sides.
    logic adv;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------- stage 1: differences
    logic signed [W-1:0] src_c [3];
    logic signed [W-1:0] tgt_c [3];
    logic [W-1:0]        s1_mag_next [3];
    logic [2:0]          s1_neg_next;

    assign src_c[0] = s_src_x;
    assign src_c[1] = s_src_y;
    assign src_c[2] = s_src_z;
    assign tgt_c[0] = s_tgt_x;
    assign tgt_c[1] = s_tgt_y;
    assign tgt_c[2] = s_tgt_z;

    always_comb begin
        logic signed [W:0] dif;
        for (int a = 0; a < 3; a++) begin
            dif = $signed({src_c[a][W-1], src_c[a]}) - $signed({tgt_c[a][W-1], tgt_c[a]});
            s1_neg_next[a] = dif[W];
            s1_mag_next[a] = dif[W] ? W'(-dif) : W'(dif);
        end
    end

    logic              s1_vld_reg;
    logic [W-1:0]      s1_mag_reg [3];
    logic [2:0]        s1_neg_reg;
    logic              s1_still_reg;
    logic [MASS_W-1:0] s1_tmass_reg;
    logic [PM_W-1:0]   s1_pm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mag_reg   <= s1_mag_next;
            s1_neg_reg   <= s1_neg_next;
            s1_still_reg <= s_tgt_still;
            s1_tmass_reg <= s_tgt_mass;
            s1_pm_reg    <= PM_W'(s_src_mass) * PM_W'(s_tgt_mass);
        end
    end

    // ------------------------------------- stage 2: largest magnitude, length
    logic [W-1:0]  mx;
    logic [LW-1:0] s2_len_next;

    always_comb begin
        mx = s1_mag_reg[0];
        if (s1_mag_reg[1] > mx) mx = s1_mag_reg[1];
        if (s1_mag_reg[2] > mx) mx = s1_mag_reg[2];
        s2_len_next = '0;
        for (int b = 0; b < W; b++) begin
            if (mx[b]) s2_len_next = LW'(b + 1);
        end
    end

    logic              s2_vld_reg;
    logic [W-1:0]      s2_mag_reg [3];
    logic [2:0]        s2_neg_reg;
    logic              s2_kill_reg;
    logic [LW-1:0]     s2_len_reg;
    logic [MASS_W-1:0] s2_tmass_reg;
    logic [PM_W-1:0]   s2_pglo_reg;
    logic [PM_W-1:0]   s2_pghi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_mag_reg   <= s1_mag_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_kill_reg  <= s1_still_reg || (mx == '0);
            s2_len_reg   <= s2_len_next;
            s2_tmass_reg <= s1_tmass_reg;
            s2_pglo_reg  <= PM_W'(s1_pm_reg[MASS_W-1:0]) * PM_W'(grav_reg);
            s2_pghi_reg  <= PM_W'(s1_pm_reg[PM_W-1:MASS_W]) * PM_W'(grav_reg);
        end
    end

    // ------------------------------------------------ stage 3: normalize
    // m = mag * 2^31 / 2^len puts the largest component in [2^30, 2^31)
    logic [NORM_W-1:0] s3_m_next [3];

    always_comb begin
        logic [W+NORM_W-1:0] ext;
        for (int a = 0; a < 3; a++) begin
            ext = {s2_mag_reg[a], NORM_W'(0)} >> s2_len_reg;
            s3_m_next[a] = ext[NORM_W-1:0];
        end
    end

    logic              s3_vld_reg;
    logic [NORM_W-1:0] s3_m_reg [3];
    logic [2:0]        s3_neg_reg;
    logic              s3_kill_reg;
    logic [LW-1:0]     s3_len_reg;
    logic [MASS_W-1:0] s3_tmass_reg;
    logic [PG_W-1:0]   s3_pg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_m_reg     <= s3_m_next;
            s3_neg_reg   <= s2_neg_reg;
            s3_kill_reg  <= s2_kill_reg;
            s3_len_reg   <= s2_len_reg;
            s3_tmass_reg <= s2_tmass_reg;
            s3_pg_reg    <= {s2_pghi_reg, MASS_W'(0)} + PG_W'(s2_pglo_reg);
        end
    end

    // ------------------------------------------------- stage 4: squares
    logic              s4_vld_reg;
    logic [SQ_W-1:0]   s4_sq_reg [3];
    logic [NORM_W-1:0] s4_m_reg [3];
    logic [2:0]        s4_neg_reg;
    logic              s4_kill_reg;
    logic [LW-1:0]     s4_len_reg;
    logic [MASS_W-1:0] s4_tmass_reg;
    logic [PG_W-1:0]   s4_pg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (adv) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                s4_sq_reg[a] <= SQ_W'(s3_m_reg[a]) * SQ_W'(s3_m_reg[a]);
            end
            s4_m_reg     <= s3_m_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_kill_reg  <= s3_kill_reg;
            s4_len_reg   <= s3_len_reg;
            s4_tmass_reg <= s3_tmass_reg;
            s4_pg_reg    <= s3_pg_reg;
        end
    end

    // ---------------------------------- stage 5: sum of squares, exponent
    logic                 s5_vld_reg;
    logic [SUM_W-1:0]     s5_sum_reg;
    logic signed [EW-1:0] s5_exp_reg;
    logic [NORM_W-1:0]    s5_m_reg [3];
    logic [2:0]           s5_neg_reg;
    logic                 s5_kill_reg;
    logic [MASS_W-1:0]    s5_tmass_reg;
    logic [PG_W-1:0]      s5_pg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (adv) begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // distance squared exponent: 2*(len - 31) - 2*COORD_FRAC
    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_sum_reg   <= SUM_W'(s4_sq_reg[0]) + SUM_W'(s4_sq_reg[1]) + SUM_W'(s4_sq_reg[2]);
            s5_exp_reg   <= EW'(2 * int'(s4_len_reg) - 2 * NORM_W - 2 * COORD_FRAC);
            s5_m_reg     <= s4_m_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_kill_reg  <= s4_kill_reg;
            s5_tmass_reg <= s4_tmass_reg;
            s5_pg_reg    <= s4_pg_reg;
        end
    end

    // -------------------------------------- stage 6: scale to whole units
    logic                   s6_over_next;
    logic [SUM_W-1:0]       s6_raw_next;

    always_comb begin
        logic [SUM_W+DSQ_W-1:0] wide;
        logic [EW-1:0]          nexp;
        wide         = '0;
        nexp         = EW'(-s5_exp_reg);
        s6_over_next = 1'b0;
        s6_raw_next  = '0;
        if (!s5_exp_reg[EW-1]) begin
            if (s5_exp_reg >= DSQ_W) begin
                s6_over_next = 1'b1;
            end else begin
                wide         = {DSQ_W'(0), s5_sum_reg} << s5_exp_reg[SH_W-1:0];
                s6_over_next = |wide[SUM_W+DSQ_W-1:DSQ_W];
                s6_raw_next  = SUM_W'(wide[DSQ_W-1:0]);
            end
        end else if (nexp < SUM_W) begin
            s6_raw_next = s5_sum_reg >> nexp[RSH_W-1:0];
        end
    end

    logic              s6_vld_reg;
    logic              s6_over_reg;
    logic [SUM_W-1:0]  s6_raw_reg;
    logic [SUM_W-1:0]  s6_sum_reg;
    logic [NORM_W-1:0] s6_m_reg [3];
    logic [2:0]        s6_neg_reg;
    logic              s6_kill_reg;
    logic [MASS_W-1:0] s6_tmass_reg;
    logic [PG_W-1:0]   s6_pg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_vld_reg <= 1'b0;
        end else if (adv) begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_over_reg  <= s6_over_next;
            s6_raw_reg   <= s6_raw_next;
            s6_sum_reg   <= s5_sum_reg;
            s6_m_reg     <= s5_m_reg;
            s6_neg_reg   <= s5_neg_reg;
            s6_kill_reg  <= s5_kill_reg;
            s6_tmass_reg <= s5_tmass_reg;
            s6_pg_reg    <= s5_pg_reg;
        end
    end

    // ---------------------------------------------- stage 7: clamp
    // lower bound is tested first and wins only below itself; a zero divisor becomes one
    logic [DSQ_W-1:0] s7_dsq_next;

    always_comb begin
        if (!s6_over_reg && (s6_raw_reg < SUM_W'(min_reg))) begin
            s7_dsq_next = min_reg;
        end else if (s6_over_reg || (s6_raw_reg >= SUM_W'(max_reg))) begin
            s7_dsq_next = max_reg;
        end else begin
            s7_dsq_next = s6_raw_reg[DSQ_W-1:0];
        end
        if (s7_dsq_next == '0) s7_dsq_next = DSQ_W'(1);
    end

    logic             s7_vld_reg;
    logic [SUM_W-1:0] s7_sum_reg;
    sq_side_t         s7_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_vld_reg <= 1'b0;
        end else if (adv) begin
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_sum_reg        <= s6_sum_reg;
            s7_side_reg.kill  <= s6_kill_reg;
            s7_side_reg.neg   <= s6_neg_reg;
            s7_side_reg.m[0]  <= s6_m_reg[0];
            s7_side_reg.m[1]  <= s6_m_reg[1];
            s7_side_reg.m[2]  <= s6_m_reg[2];
            s7_side_reg.pg    <= s6_pg_reg;
            s7_side_reg.dsq   <= s7_dsq_next;
            s7_side_reg.tmass <= s6_tmass_reg;
        end
    end

    // ------------------------------------------------ vector length
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_side;

    pga_sqrt_pipe #(
        .RW (ROOT_W),
        .SW ($bits(sq_side_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s7_vld_reg),
        .rad_in    (s7_sum_reg),
        .side_in   (s7_side_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ----------------------------------- unit vector: u = m * 2^31 / length
    // m >> 1 stays below the length, so only 32 quotient bits are needed
    ud_side_t          ud_side_in;
    ud_side_t          ud_side_out;
    logic [2:0]        ud_vld;
    logic [UNIT_W-1:0] ud_u [3];
    logic              ud_neg1;
    logic              ud_neg2;

    assign ud_side_in.kill  = sq_side.kill;
    assign ud_side_in.neg   = sq_side.neg[0];
    assign ud_side_in.pg    = sq_side.pg;
    assign ud_side_in.dsq   = sq_side.dsq;
    assign ud_side_in.tmass = sq_side.tmass;

    pga_div_pipe #(
        .DW (ROOT_W),
        .QW (UNIT_W),
        .SW ($bits(ud_side_t))
    ) u_unit_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_vld),
        .rem_in    (ROOT_W'(sq_side.m[0][NORM_W-1:1])),
        .num_in    ({sq_side.m[0][0], (UNIT_W-1)'(0)}),
        .den_in    (sq_root),
        .side_in   (ud_side_in),
        .out_valid (ud_vld[0]),
        .quot      (ud_u[0]),
        .side_out  (ud_side_out)
    );

    pga_div_pipe #(
        .DW (ROOT_W),
        .QW (UNIT_W),
        .SW (1)
    ) u_unit_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_vld),
        .rem_in    (ROOT_W'(sq_side.m[1][NORM_W-1:1])),
        .num_in    ({sq_side.m[1][0], (UNIT_W-1)'(0)}),
        .den_in    (sq_root),
        .side_in   (sq_side.neg[1]),
        .out_valid (ud_vld[1]),
        .quot      (ud_u[1]),
        .side_out  (ud_neg1)
    );

    pga_div_pipe #(
        .DW (ROOT_W),
        .QW (UNIT_W),
        .SW (1)
    ) u_unit_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_vld),
        .rem_in    (ROOT_W'(sq_side.m[2][NORM_W-1:1])),
        .num_in    ({sq_side.m[2][0], (UNIT_W-1)'(0)}),
        .den_in    (sq_root),
        .side_in   (sq_side.neg[2]),
        .out_valid (ud_vld[2]),
        .quot      (ud_u[2]),
        .side_out  (ud_neg2)
    );

    // ---------------------- strength = m1 * m2 * G / clamped distance squared
    d1_side_t        d1_side_in;
    d1_side_t        d1_side_out;
    logic            d1_vld;
    logic [PG_W-1:0] d1_q;

    assign d1_side_in.kill  = ud_side_out.kill;
    assign d1_side_in.neg   = {ud_neg2, ud_neg1, ud_side_out.neg};
    assign d1_side_in.u[0]  = ud_u[0];
    assign d1_side_in.u[1]  = ud_u[1];
    assign d1_side_in.u[2]  = ud_u[2];
    assign d1_side_in.tmass = ud_side_out.tmass;

    pga_div_pipe #(
        .DW (DSQ_W),
        .QW (PG_W),
        .SW ($bits(d1_side_t))
    ) u_strength (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (&ud_vld),
        .rem_in    ('0),
        .num_in    (ud_side_out.pg),
        .den_in    (ud_side_out.dsq),
        .side_in   (d1_side_in),
        .out_valid (d1_vld),
        .quot      (d1_q),
        .side_out  (d1_side_out)
    );

    // ------------------------------- force scale: partial products, then sum
    localparam int SP_W = MASS_W + SCALE_W;

    logic            sa_vld_reg;
    logic [SP_W-1:0] sa_pp_reg [3];
    d1_side_t        sa_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_vld_reg <= 1'b0;
        end else if (adv) begin
            sa_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                sa_pp_reg[j] <= SP_W'(d1_q[j*MASS_W +: MASS_W]) * SP_W'(scale_reg);
            end
            sa_side_reg <= d1_side_out;
        end
    end

    // massless target: divide the unshifted force by one
    logic [F_W-1:0] sb_force;
    assign sb_force = F_W'(sa_pp_reg[0]) + (F_W'(sa_pp_reg[1]) << MASS_W)
                    + (F_W'(sa_pp_reg[2]) << (2 * MASS_W));

    logic              sb_vld_reg;
    logic [N2_W-1:0]   sb_num_reg;
    logic [MASS_W-1:0] sb_den_reg;
    d2_side_t          sb_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_vld_reg <= 1'b0;
        end else if (adv) begin
            sb_vld_reg <= sa_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (sa_side_reg.tmass != '0) begin
                sb_num_reg <= {sb_force, 16'd0};
                sb_den_reg <= sa_side_reg.tmass;
            end else begin
                sb_num_reg <= N2_W'(sb_force);
                sb_den_reg <= MASS_W'(1);
            end
            sb_side_reg.kill <= sa_side_reg.kill;
            sb_side_reg.neg  <= sa_side_reg.neg;
            sb_side_reg.u    <= sa_side_reg.u;
        end
    end

    // ------------------------------------------ divide by target mass
    logic            d2_vld;
    logic [N2_W-1:0] d2_q;
    d2_side_t        d2_side;

    pga_div_pipe #(
        .DW (MASS_W),
        .QW (N2_W),
        .SW ($bits(d2_side_t))
    ) u_mass_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sb_vld_reg),
        .rem_in    ('0),
        .num_in    (sb_num_reg),
        .den_in    (sb_den_reg),
        .side_in   (sb_side_reg),
        .out_valid (d2_vld),
        .quot      (d2_q),
        .side_out  (d2_side)
    );

    // --------------------------------------------- clip force below 2^95
    logic              cl_vld_reg;
    logic [CLIP_W-1:0] cl_force_reg;
    d2_side_t          cl_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_vld_reg <= 1'b0;
        end else if (adv) begin
            cl_vld_reg <= d2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cl_force_reg <= (|d2_q[N2_W-1:CLIP_W]) ? '1 : d2_q[CLIP_W-1:0];
            cl_side_reg  <= d2_side;
        end
    end

    // ------------------------- force times unit component, 32-bit partials
    localparam int PP_W = 2 * UNIT_W;

    logic            mu_vld_reg;
    logic [PP_W-1:0] mu_pp_reg [3][3];
    logic            mu_kill_reg;
    logic [2:0]      mu_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_vld_reg <= 1'b0;
        end else if (adv) begin
            mu_vld_reg <= cl_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                mu_pp_reg[a][0] <= PP_W'(cl_force_reg[31:0]) * PP_W'(cl_side_reg.u[a]);
                mu_pp_reg[a][1] <= PP_W'(cl_force_reg[63:32]) * PP_W'(cl_side_reg.u[a]);
                mu_pp_reg[a][2] <= PP_W'(cl_force_reg[CLIP_W-1:64]) * PP_W'(cl_side_reg.u[a]);
            end
            mu_kill_reg <= cl_side_reg.kill;
            mu_neg_reg  <= cl_side_reg.neg;
        end
    end

    logic             ps_vld_reg;
    logic [PRD_W-1:0] ps_prod_reg [3];
    logic             ps_kill_reg;
    logic [2:0]       ps_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_vld_reg <= 1'b0;
        end else if (adv) begin
            ps_vld_reg <= mu_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                ps_prod_reg[a] <= PRD_W'(mu_pp_reg[a][0]) + (PRD_W'(mu_pp_reg[a][1]) << 32)
                                + (PRD_W'(mu_pp_reg[a][2]) << 64);
            end
            ps_kill_reg <= mu_kill_reg;
            ps_neg_reg  <= mu_neg_reg;
        end
    end

    // ------------------------------- output: shift to Q32.16, sign, saturate
    logic [ACC_W-1:0] acc_next [3];
    logic             sat_next;

    always_comb begin
        logic [R_W-1:0] r;
        sat_next = 1'b0;
        for (int a = 0; a < 3; a++) begin
            r = ps_prod_reg[a][PRD_W-1:SHR];
            if (ps_neg_reg[a]) begin
                if (r > R_NEG_LIM) begin
                    r        = R_NEG_LIM;
                    sat_next = 1'b1;
                end
                acc_next[a] = ACC_W'(R_W'(0) - r);
            end else begin
                if (r > R_POS_LIM) begin
                    r        = R_POS_LIM;
                    sat_next = 1'b1;
                end
                acc_next[a] = r[ACC_W-1:0];
            end
        end
        // still target or coincident bodies
        if (ps_kill_reg) begin
            for (int a = 0; a < 3; a++) acc_next[a] = '0;
            sat_next = 1'b0;
        end
    end

    logic [ACC_W-1:0] acc_reg [3];
    logic             sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= ps_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg <= acc_next;
            sat_reg <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_acc_x     = $signed(acc_reg[0]);
    assign m_acc_y     = $signed(acc_reg[1]);
    assign m_acc_z     = $signed(acc_reg[2]);
    assign m_saturated = sat_reg;

endmodule

`default_nettype wire

/* hdl/pga_checker.sv */
// Port-level checks of the pairwise gravity block, bound to its top level.
// Depends on pga_pkg and pairwise_gravity_accel_top.
`default_nettype none

module pga_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [pga_pkg::ACC_W-1:0] m_acc_x,
    input logic signed [pga_pkg::ACC_W-1:0] m_acc_y,
    input logic signed [pga_pkg::ACC_W-1:0] m_acc_z,
    input logic                             m_saturated
);

    import pga_pkg::*;

    // a free output side never blocks the input side
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with no pending result");

    // a saturated result shows at least one component at a range limit
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_acc_x == ACC_POS_MAX || m_acc_x == ACC_NEG_MIN ||
             m_acc_y == ACC_POS_MAX || m_acc_y == ACC_NEG_MIN ||
             m_acc_z == ACC_POS_MAX || m_acc_z == ACC_NEG_MIN))
        else $error("saturated flag without a clipped component");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_acc_x) && $stable(m_acc_y) && $stable(m_acc_z)
             && $stable(m_saturated)))
        else $error("result changed under stall");

endmodule

bind pairwise_gravity_accel_top pga_checker u_pga_checker (.*);

`default_nettype wire

/* tb/pairwise_gravity_accel_top_test.sv */
// Self-checking testbench of pairwise_gravity_accel_top: directed body pairs, then random pairs.
// Every output transaction is checked against its row's written result or a bit-exact predictor.
// Depends on pga_pkg and the RTL of pairwise_gravity_accel_top.
`timescale 1ns / 100ps

module pairwise_gravity_accel_top_test;
    import pga_pkg::*;

    localparam int CW       = COORD_WIDTH_DEF;
    localparam int CF       = COORD_FRAC_DEF;
    localparam int DRAIN    = 320;   // pipeline is about 301 deep
    localparam int HOLD_LEN = 700;   // long enough to fill the pipeline
    localparam int PHASE_N  = 300;
    localparam int PRESS_N  = 500;   // more pairs than the pipeline holds

    typedef struct packed {
        logic signed [CW-1:0] sx, sy, sz, tx, ty, tz;
        logic [MASS_W-1:0]    sm, tm;
        logic                 still;
    } body_pair_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] ax, ay, az;
        logic                    sat;
    } accel_t;

    typedef struct packed {
        body_pair_t p;
        logic       typed;   // expected result written in the row
        accel_t     a;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_src_x = '0, s_src_y = '0, s_src_z = '0;
    logic signed [CW-1:0] s_tgt_x = '0, s_tgt_y = '0, s_tgt_z = '0;
    logic [MASS_W-1:0] s_src_mass = '0, s_tgt_mass = '0;
    logic s_tgt_still = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [ACC_W-1:0] m_acc_x, m_acc_y, m_acc_z;
    logic m_saturated;

    // predictor copy of the registers
    logic [GRAV_W-1:0]  grav_k  = GRAV_RST;
    logic [SCALE_W-1:0] f_scale = SCALE_RST;
    logic [DSQ_W-1:0]   dsq_lo  = MIN_RST;
    logic [DSQ_W-1:0]   dsq_hi  = MAX_RST;

    accel_t pending_accel[$];
    int     n_errors = 0;
    bit     quiet = 0;          // no idling on either side
    int     stall_req = 0;      // bumped to ask the receiver for a long hold-off

    pairwise_gravity_accel_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_src_x(s_src_x), .s_src_y(s_src_y), .s_src_z(s_src_z),
        .s_tgt_x(s_tgt_x), .s_tgt_y(s_tgt_y), .s_tgt_z(s_tgt_z),
        .s_src_mass(s_src_mass), .s_tgt_mass(s_tgt_mass), .s_tgt_still(s_tgt_still),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_acc_x(m_acc_x), .m_acc_y(m_acc_y), .m_acc_z(m_acc_z),
        .m_saturated(m_saturated)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Generous hard limit; a correct run needs far less.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Bit-exact acceleration of the target toward the source.
    function automatic accel_t gravity_accel(body_pair_t p);
        logic signed [CW:0] d;
        logic [CW:0]   mag[3];
        bit            neg[3];
        logic [CW-1:0] sp[3], tp[3];
        logic [63:0]   m[3], mx, sum_sq, len, u, r, dsq;
        logic [127:0]  f, pw;
        logic [ACC_W-1:0] comp[3];
        int  bl, sh, e;
        bit  sat;
        accel_t a;
        a = '0;
        sat = 0;
        sp[0] = p.sx; sp[1] = p.sy; sp[2] = p.sz;
        tp[0] = p.tx; tp[1] = p.ty; tp[2] = p.tz;
        for (int i = 0; i < 3; i++) begin
            d = {sp[i][CW-1], sp[i]} - {tp[i][CW-1], tp[i]};
            neg[i] = d[CW];
            mag[i] = neg[i] ? -d : d;
        end
        if (p.still) return a;
        mx = 64'(mag[0]);
        if (64'(mag[1]) > mx) mx = 64'(mag[1]);
        if (64'(mag[2]) > mx) mx = 64'(mag[2]);
        if (mx == 0) return a;
        // normalize so the largest component sits in [2^30, 2^31)
        bl = 0;
        while (bl < 64 && (mx >> bl) != 0) bl++;
        sh = bl - 31;
        for (int i = 0; i < 3; i++)
            m[i] = (sh >= 0) ? (64'(mag[i]) >> sh) : (64'(mag[i]) << (-sh));
        sum_sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum_sq);
        e = 2 * sh - 2 * CF;
        if (e >= 0) begin
            if (e >= 32 || sum_sq > (64'hFFFF_FFFF >> e)) dsq = 64'd1 << 32;
            else dsq = sum_sq << e;
        end else begin
            dsq = (-e >= 64) ? 64'd0 : (sum_sq >> (-e));
        end
        if (dsq < 64'(dsq_lo)) dsq = 64'(dsq_lo);
        else if (dsq >= 64'(dsq_hi)) dsq = 64'(dsq_hi);
        if (dsq == 0) dsq = 1;
        f = 128'(p.sm) * 128'(p.tm);
        f = f * 128'(grav_k);
        f = f / 128'(dsq);
        f = f * 128'(f_scale);
        if (p.tm != 0) f = (f << 16) / 128'(p.tm);
        if (f[127:95] != 0) f = {33'd0, {95{1'b1}}};
        for (int i = 0; i < 3; i++) begin
            u = (m[i] << 31) / len;
            pw = f * 128'(u);
            r = pw[110:47];
            if (neg[i]) begin
                if ((|pw[127:111]) || r > (64'd1 << 47)) begin
                    r = 64'd1 << 47;
                    sat = 1;
                end
                comp[i] = -r[ACC_W-1:0];
            end else begin
                if ((|pw[127:111]) || r > (64'd1 << 47) - 1) begin
                    r = (64'd1 << 47) - 1;
                    sat = 1;
                end
                comp[i] = r[ACC_W-1:0];
            end
        end
        a.ax = comp[0]; a.ay = comp[1]; a.az = comp[2]; a.sat = sat;
        return a;
    endfunction

    // Output side: check each transaction, then pick the next m_ready.
    int hold_left = 0;
    int stall_seen = 0;
    always @(posedge aclk) begin
        accel_t want;
        if (m_valid && m_ready) begin
            if (pending_accel.size() == 0) begin
                $error("unexpected output transaction");
                n_errors++;
            end else begin
                want = pending_accel.pop_front();
                if (m_acc_x !== want.ax) begin
                    $error("acc_x exp %0d got %0d", want.ax, m_acc_x); n_errors++;
                end
                if (m_acc_y !== want.ay) begin
                    $error("acc_y exp %0d got %0d", want.ay, m_acc_y); n_errors++;
                end
                if (m_acc_z !== want.az) begin
                    $error("acc_z exp %0d got %0d", want.az, m_acc_z); n_errors++;
                end
                if (m_saturated !== want.sat) begin
                    $error("saturated exp %0b got %0b", want.sat, m_saturated); n_errors++;
                end
            end
        end
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // Called at a clock edge; returns at the edge where the transaction is taken.
    task automatic offer_pair(body_pair_t p, bit typed, accel_t a);
        if (!quiet && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 30);
        end
        s_valid <= 1'b1;
        {s_src_x, s_src_y, s_src_z} <= {p.sx, p.sy, p.sz};
        {s_tgt_x, s_tgt_y, s_tgt_z} <= {p.tx, p.ty, p.tz};
        s_src_mass <= p.sm;
        s_tgt_mass <= p.tm;
        s_tgt_still <= p.still;
        do @(posedge aclk); while (!s_ready);
        pending_accel.push_back(typed ? a : gravity_accel(p));
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_GRAV:  grav_k  = val;
            CFG_SCALE: f_scale = val[SCALE_W-1:0];
            CFG_MIN:   dsq_lo  = val;
            CFG_MAX:   dsq_hi  = val;
            default: begin
            end
        endcase
    endtask

    task automatic load_regs(logic [31:0] g, logic [31:0] sc, logic [31:0] lo, logic [31:0] hi);
        write_reg(CFG_GRAV, g);
        write_reg(CFG_SCALE, sc);
        write_reg(CFG_MIN, lo);
        write_reg(CFG_MAX, hi);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait out every pending result, then the pipeline depth.
    task automatic drain_pipe();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_accel.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord_delta();
        case ($urandom_range(3))
            0: return $urandom_range(4095) - 2048;
            1: return $urandom_range(1 << 21) - (1 << 20);
            2: return $urandom_range(1 << 27) - (1 << 26);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom_range(1 << 16);
            2: return $urandom_range(1 << 24);
            default: return $urandom;
        endcase
    endfunction

    // Mostly nearby pairs so the clamp window is hit; some fully random positions.
    function automatic body_pair_t rand_pair();
        body_pair_t p;
        p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
        p.tx = p.sx + rand_coord_delta();
        p.ty = p.sy + rand_coord_delta();
        p.tz = p.sz + rand_coord_delta();
        if ($urandom_range(15) == 0) p.ty = p.sy;
        p.sm = rand_mass();
        p.tm = rand_mass();
        p.still = ($urandom_range(9) == 0);
        return p;
    endfunction

    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PMIN = 32'h8000_0000;
    localparam logic [31:0] M1   = 32'h0001_0000;   // 1.0 in Q16.16
    localparam logic [31:0] MMAX = 32'hFFFF_FFFF;

    // sx sy sz tx ty tz sm tm still | typed | expected
    stim_row_t stim_rows[] = '{
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, M1, M1, 1'b0}, 1'b1, '0},
        '{'{PMAX, PMIN, 32'd5, PMAX, PMIN, 32'd5, MMAX, MMAX, 1'b0}, 1'b1, '0},
        '{'{PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, MMAX, MMAX, 1'b1}, 1'b1, '0},
        '{'{32'd25600, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, M1, 1'b0}, 1'b1, '0},
        '{'{32'd25600, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, M1, M1, 1'b0}, 1'b0, '0},
        '{'{32'd0, 32'd25600, 32'd0, 32'd0, 32'd0, 32'd0, M1, M1, 1'b0}, 1'b0, '0},
        '{'{32'd0, 32'd0, -32'd25600, 32'd0, 32'd0, 32'd0, M1, M1, 1'b0}, 1'b0, '0},
        '{'{32'd256, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, M1, M1, 1'b0}, 1'b0, '0},
        '{'{PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, M1, M1, 1'b0}, 1'b0, '0},
        '{'{PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, M1, M1, 1'b0}, 1'b0, '0},
        '{'{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, MMAX, MMAX, 1'b0}, 1'b0, '0},
        '{'{-32'd1, -32'd1, 32'd1, 32'd0, 32'd0, 32'd0, MMAX, 32'd0, 1'b0}, 1'b0, '0},
        '{'{32'd3000, -32'd4000, 32'd0, 32'd0, 32'd0, 32'd0, M1, 32'd0, 1'b0}, 1'b0, '0},
        '{'{32'd3000, -32'd4000, 32'd0, 32'd0, 32'd0, 32'd0, MMAX, 32'd1, 1'b0}, 1'b0, '0},
        '{'{32'h0012_3456, 32'h00AB_CDEF, -32'h0001_0000, 32'd0, 32'd0, 32'd0, M1, MMAX, 1'b0},
          1'b0, '0},
        '{'{32'h5555_5555, 32'h2AAA_AAAA, 32'h1234_5678, 32'hAAAA_AAAA, 32'hD555_5555,
            32'hEDCB_A987, 32'h8000_0001, 32'h0000_FFFF, 1'b0}, 1'b0, '0}
    };

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            // a calm stretch in the middle of every phase
            quiet = (k >= count / 3) && (k < count / 2);
            offer_pair(rand_pair(), 1'b0, '0);
        end
        quiet = 0;
        drain_pipe();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset register values, directed rows first.
        foreach (stim_rows[i])
            offer_pair(stim_rows[i].p, stim_rows[i].typed, stim_rows[i].a);
        random_phase(PHASE_N);

        // Largest constant and scale, widest clamp window.
        load_regs(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd0, 32'hFFFF_FFFF);
        foreach (stim_rows[i])
            offer_pair(stim_rows[i].p, 1'b0, '0);
        random_phase(PHASE_N);

        // Both bounds zero: every clamped distance becomes the divisor of one.
        load_regs(32'd1, 32'd1, 32'd0, 32'd0);
        random_phase(PHASE_N / 2);

        // Crossed bounds, lower above upper.
        load_regs($urandom, $urandom_range(65535), 32'd50000, 32'd100);
        random_phase(PHASE_N / 2);

        // Random registers; receiver holds off long enough to back up the input.
        load_regs($urandom, $urandom_range(65535), $urandom_range(1 << 20), $urandom);
        stall_req++;
        random_phase(PRESS_N);

        // Zero constant and zero scale.
        load_regs(32'd0, 32'd0, $urandom, $urandom);
        random_phase(PHASE_N / 3);

        // Back to the reset values.
        load_regs(GRAV_RST, SCALE_RST, MIN_RST, MAX_RST);
        random_phase(PHASE_N);

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* pairwise_gravity_accel_top.f */
hdl/pga_pkg.sv
hdl/pga_div_pipe.sv
hdl/pga_sqrt_pipe.sv
hdl/pairwise_gravity_accel_top.sv
hdl/pga_checker.sv
tb/pairwise_gravity_accel_top_test.sv
